FILE: src/orbwa_pkg.sv
// shared types and constants for the overwriting ring buffer with average
`default_nettype none

package orbwa_pkg;

    // default configuration
    localparam int DEPTH_DEF      = 8;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed port widths
    localparam int MODE_W      = 2;
    localparam int WORD_W      = 32;
    localparam int COUNT_OUT_W = 4;
    localparam int MEAN_W      = 40;
    localparam int FRAC_BITS   = 8;

    // item operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV_LOAD,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic do_update;
        logic div_load;
        logic div_step;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic count_zero;
        logic div_last;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: src/orbwa_ram.sv
// generic single-port-write ram with registered read
`default_nettype none

module orbwa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: src/orbwa_ctrl.sv
// sequencing state machine for the ring buffer
`default_nettype none

module orbwa_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output orbwa_pkg::ctrl_cmd_t         cmd,
    input  wire orbwa_pkg::dp_status_t   status
);

    import orbwa_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.do_update = 1'b1;
                state_next    = ST_DIV_LOAD;
            end
            ST_DIV_LOAD:
            begin
                // empty buffer has no mean to compute
                if (status.count_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // output register free or emptied this cycle
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: src/orbwa_dp.sv
// buffer state, running sum, serial divider and result registers
`default_nettype none

module orbwa_dp #(
    parameter int DEPTH      = orbwa_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = orbwa_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire orbwa_pkg::ctrl_cmd_t                   cmd,
    output orbwa_pkg::dp_status_t                       status,
    input  wire logic [orbwa_pkg::MODE_W-1:0]           mode,
    input  wire logic signed [orbwa_pkg::WORD_W-1:0]    write_value,
    output logic                                        ram_wr_en,
    output logic [$clog2(DEPTH)-1:0]                    ram_wr_addr,
    output logic [DATA_WIDTH-1:0]                       ram_wr_data,
    output logic                                        ram_rd_en,
    output logic [$clog2(DEPTH)-1:0]                    ram_rd_addr,
    input  wire logic [DATA_WIDTH-1:0]                  ram_rd_data,
    output logic signed [orbwa_pkg::WORD_W-1:0]         read_data,
    output logic                                        read_ok,
    output logic                                        underflow,
    output logic [orbwa_pkg::COUNT_OUT_W-1:0]           entry_count,
    output logic                                        is_full,
    output logic                                        is_empty,
    output logic signed [orbwa_pkg::MEAN_W-1:0]         mean_value,
    output logic                                        mean_valid
);

    import orbwa_pkg::*;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = DATA_WIDTH + $clog2(DEPTH);
    localparam int DIV_W  = SUM_W + FRAC_BITS;
    localparam int STEP_W = $clog2(DIV_W);
    localparam int EXT_W  = (DIV_W > MEAN_W) ? DIV_W : MEAN_W;

    // captured item
    mode_t                  mode_reg;
    logic [DATA_WIDTH-1:0]  value_reg;

    // buffer state
    logic [IDX_W-1:0]       wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;

    // per-item read result
    logic [WORD_W-1:0]      rdata_reg, rdata_next;
    logic                   rok_reg, rok_next;
    logic                   uflow_reg, uflow_next;

    // divider
    logic [CNT_W-1:0]       rem_reg;
    logic [DIV_W-1:0]       quo_reg;
    logic [STEP_W-1:0]      step_reg;
    logic                   neg_reg;
    logic [SUM_W-1:0]       mag;
    logic [CNT_W:0]         trial;
    logic                   trial_ge;
    logic [CNT_W:0]         trial_sub;

    logic                   buf_full;
    logic signed [SUM_W-1:0] old_word;
    logic signed [SUM_W-1:0] new_word;
    logic [IDX_W-1:0]       wr_idx_inc;
    logic [IDX_W-1:0]       rd_idx_inc;
    logic [EXT_W-1:0]       q_ext;
    logic [EXT_W-1:0]       q_signed;

    assign buf_full   = (count_reg == CNT_W'(DEPTH));
    assign old_word   = SUM_W'($signed(ram_rd_data));
    assign new_word   = SUM_W'($signed(value_reg));
    assign wr_idx_inc = (wr_idx_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
    assign rd_idx_inc = (rd_idx_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_idx_reg + 1'b1;

    // oldest entry fetched at accept, data is back in the update cycle
    assign ram_rd_en   = cmd.accept;
    assign ram_rd_addr = rd_idx_reg;
    assign ram_wr_en   = cmd.do_update && (mode_reg == MODE_WRITE);
    assign ram_wr_addr = wr_idx_reg;
    assign ram_wr_data = value_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg  <= mode_t'(mode);
            value_reg <= write_value[DATA_WIDTH-1:0];
        end
    end

    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        rdata_next  = '0;
        rok_next    = 1'b0;
        uflow_next  = 1'b0;
        case (mode_reg)
            MODE_WRITE:
            begin
                wr_idx_next = wr_idx_inc;
                if (buf_full)
                begin
                    // overwrite oldest
                    rd_idx_next = rd_idx_inc;
                    sum_next    = sum_reg - old_word + new_word;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    sum_next   = sum_reg + new_word;
                end
            end
            MODE_READ:
            begin
                if (count_reg == '0)
                begin
                    uflow_next = 1'b1;
                end
                else
                begin
                    rd_idx_next = rd_idx_inc;
                    count_next  = count_reg - 1'b1;
                    sum_next    = sum_reg - old_word;
                    rdata_next  = WORD_W'($signed(ram_rd_data));
                    rok_next    = 1'b1;
                end
            end
            MODE_CLEAR:
            begin
                wr_idx_next = '0;
                rd_idx_next = '0;
                count_next  = '0;
                sum_next    = '0;
            end
            MODE_QUERY:
            begin
                sum_next = sum_reg;
            end
            default:
            begin
                sum_next = sum_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
        end
        else if (cmd.do_update)
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_update)
        begin
            rdata_reg <= rdata_next;
            rok_reg   <= rok_next;
            uflow_reg <= uflow_next;
        end
    end

    // restoring divider, one quotient bit per cycle, dividend shifts out of quo_reg
    assign mag       = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign trial     = {rem_reg, quo_reg[DIV_W-1]};
    assign trial_ge  = (trial >= {1'b0, count_reg});
    assign trial_sub = trial - {1'b0, count_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            rem_reg  <= '0;
            quo_reg  <= {mag, {FRAC_BITS{1'b0}}};
            step_reg <= '0;
            neg_reg  <= sum_reg[SUM_W-1];
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_reg  <= {quo_reg[DIV_W-2:0], trial_ge};
            step_reg <= step_reg + 1'b1;
        end
    end

    assign status.count_zero = (count_reg == '0);
    assign status.div_last   = (step_reg == STEP_W'(DIV_W - 1));

    assign q_ext    = EXT_W'(quo_reg);
    assign q_signed = neg_reg ? (EXT_W'(0) - q_ext) : q_ext;

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            read_data   <= rdata_reg;
            read_ok     <= rok_reg;
            underflow   <= uflow_reg;
            entry_count <= COUNT_OUT_W'(count_reg);
            is_full     <= buf_full;
            is_empty    <= (count_reg == '0);
            mean_valid  <= (count_reg != '0);
            mean_value  <= (count_reg == '0) ? '0 : q_signed[MEAN_W-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: src/overwriting_ring_buffer_with_average_core.sv
// top level of the overwriting ring buffer with running mean
`default_nettype none

// Ring buffer of DEPTH signed words of DATA_WIDTH bits that drops its oldest
// word when written while full. Each input beat carries a mode (write, read
// oldest, clear, query) and produces exactly one output beat with the word
// read, the held count, full and empty flags and the mean of the held words
// as signed fixed point with 8 fractional bits, truncated toward zero. One
// beat is handled at a time: accept, an update state (the oldest word is
// fetched from the RAM at accept so its value is subtracted from the running
// sum there), a divider load state, then a restoring divider producing one
// quotient bit per cycle over the scaled sum (DATA_WIDTH + log2(DEPTH) + 8
// bits, 43 at the default size), and a final state that loads the output
// register. The divider is skipped when the buffer is left empty. in_stall is
// high while a beat is in progress; a finished result waits in the output
// register and stalls only the final load state of the following beat.
// entry_count shows the low 4 bits of the held count.

module overwriting_ring_buffer_with_average_core #(
    parameter int DEPTH      = orbwa_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = orbwa_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // input channel
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [orbwa_pkg::MODE_W-1:0]           mode,
    input  wire logic signed [orbwa_pkg::WORD_W-1:0]    write_value,
    // output channel
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic signed [orbwa_pkg::WORD_W-1:0]         read_data,
    output logic                                        read_ok,
    output logic                                        underflow,
    output logic [orbwa_pkg::COUNT_OUT_W-1:0]           entry_count,
    output logic                                        is_full,
    output logic                                        is_empty,
    output logic signed [orbwa_pkg::MEAN_W-1:0]         mean_value,
    output logic                                        mean_valid
);

    import orbwa_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    ctrl_cmd_t              cmd;
    dp_status_t             status;

    // entry store port signals
    logic                   ram_wr_en;
    logic [IDX_W-1:0]       ram_wr_addr;
    logic [DATA_WIDTH-1:0]  ram_wr_data;
    logic                   ram_rd_en;
    logic [IDX_W-1:0]       ram_rd_addr;
    logic [DATA_WIDTH-1:0]  ram_rd_data;

    // sequencing: accept, update, divide, hand result to output register
    orbwa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    // indices, count, running sum, divider and output registers
    orbwa_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .mode        (mode),
        .write_value (write_value),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .read_data   (read_data),
        .read_ok     (read_ok),
        .underflow   (underflow),
        .entry_count (entry_count),
        .is_full     (is_full),
        .is_empty    (is_empty),
        .mean_value  (mean_value),
        .mean_valid  (mean_valid)
    );

    // entry store; no reset, only data from written slots is ever used
    orbwa_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire

FILE: src/orbwa_checker.sv
// port-level assertions for the ring buffer, bound to the top level
`default_nettype none

module orbwa_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_stall,
    input wire logic                                out_valid,
    input wire logic                                out_stall,
    input wire logic signed [orbwa_pkg::WORD_W-1:0] read_data,
    input wire logic                                read_ok,
    input wire logic                                underflow,
    input wire logic                                is_full,
    input wire logic                                is_empty,
    input wire logic signed [orbwa_pkg::MEAN_W-1:0] mean_value,
    input wire logic                                mean_valid
);

    // one beat at a time: intake closes right after an accept
    a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while a beat is in progress");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data)
            && $stable(mean_value) && $stable(is_empty))
        else $error("stalled output beat changed");

    // underflow only on an empty buffer, with no data
    a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && underflow |-> is_empty && !read_ok && (read_data == '0))
        else $error("underflow with inconsistent flags");

    // mean valid exactly when nonempty, zero otherwise, full never empty
    a_mean_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mean_valid != is_empty) && !(is_full && is_empty)
            && (mean_valid || (mean_value == '0)))
        else $error("status flags disagree");

endmodule

bind overwriting_ring_buffer_with_average_core orbwa_checker u_orbwa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data),
    .read_ok    (read_ok),
    .underflow  (underflow),
    .is_full    (is_full),
    .is_empty   (is_empty),
    .mean_value (mean_value),
    .mean_valid (mean_valid)
);

`default_nettype wire
